// ----- src/lpr_pkg.sv -----
// Package with the sizes, codes and shared types of the LRU page replacement block.
`timescale 1ns / 1ps
`default_nettype none
package lpr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int FIDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W     = 4;
  localparam int FAULT_W   = 32;
  localparam int FRAME_W   = 3;
  localparam int EVPAGE_W  = 16;

  localparam logic [CNT_W-1:0] FRAMES_RESET = CNT_W'(FRAMES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  typedef struct packed {
    logic                hit;
    logic [FRAME_W-1:0]  frame;
    logic                evicted_valid;
    logic [EVPAGE_W-1:0] evicted_page;
    logic [FAULT_W-1:0]  fault_count;
  } res_t;

endpackage
`default_nettype wire

// ----- src/lpr_if.sv -----
// Interfaces of the request and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface lpr_in_if import lpr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;
  logic                 end_of_string;

  modport source (output valid, output page, output end_of_string, input ready);
  modport sink (input valid, input page, input end_of_string, output ready);
endinterface

interface lpr_out_if import lpr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                hit;
  logic [FRAME_W-1:0]  frame;
  logic                evicted_valid;
  logic [EVPAGE_W-1:0] evicted_page;
  logic [FAULT_W-1:0]  fault_count;

  modport source (output valid, output hit, output frame, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink (input valid, input hit, input frame, input evicted_valid,
                input evicted_page, input fault_count, output ready);
endinterface
`default_nettype wire

// ----- src/lpr_ctrl.sv -----
// Controller state machine that sequences capture, lookup and result delivery.
`timescale 1ns / 1ps
`default_nettype none
module lpr_ctrl import lpr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_HOLD;
      ST_HOLD: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready    = (state == ST_IDLE);
  assign out_valid   = (state == ST_HOLD);
  assign cmd.capture = (state == ST_IDLE) && in_valid;
  assign cmd.execute = (state == ST_EXEC);

endmodule
`default_nettype wire

// ----- src/lpr_dp.sv -----
// Datapath with frame store, recency order, fault counter and result registers.
`timescale 1ns / 1ps
`default_nettype none
module lpr_dp import lpr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  input  wire logic [PAGE_BITS-1:0] page,
  input  wire logic                 end_of_string,
  input  wire logic                 cfg_we,
  input  wire logic [CNT_W-1:0]     cfg_data,
  output res_t                      res
);

  logic [PAGE_BITS-1:0] frame_page [FRAMES];
  logic [FRAMES-1:0]    frame_valid;
  logic [FIDX_W-1:0]    order [FRAMES];
  logic [FIDX_W-1:0]    order_next [FRAMES];
  logic [FAULT_W-1:0]   faults;
  logic [FAULT_W-1:0]   faults_next;
  logic [CNT_W-1:0]     frames_in_use;
  logic [PAGE_BITS-1:0] page_q;
  logic                 last_q;

  logic [CNT_W-1:0]  n_eff;
  logic              hit;
  logic [FIDX_W-1:0] hit_idx;
  logic              empty_found;
  logic [FIDX_W-1:0] empty_idx;
  logic [FIDX_W-1:0] lru_idx;
  logic [FIDX_W-1:0] f;
  logic              evict;
  logic [FIDX_W-1:0] pos;

  always_comb begin
    if (frames_in_use == '0) begin
      n_eff = CNT_W'(1);
    end else if (frames_in_use > FRAMES_RESET) begin
      n_eff = FRAMES_RESET;
    end else begin
      n_eff = frames_in_use;
    end
  end

  always_comb begin
    hit         = 1'b0;
    hit_idx     = '0;
    empty_found = 1'b0;
    empty_idx   = '0;
    lru_idx     = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < n_eff) && frame_valid[i] && (frame_page[i] == page_q)) begin
        hit     = 1'b1;
        hit_idx = FIDX_W'(i);
      end
      if ((CNT_W'(i) < n_eff) && !frame_valid[i]) begin
        empty_found = 1'b1;
        empty_idx   = FIDX_W'(i);
      end
      if (CNT_W'(order[i]) < n_eff) begin
        lru_idx = order[i];
      end
    end
  end

  always_comb begin
    if (hit) begin
      f = hit_idx;
    end else if (empty_found) begin
      f = empty_idx;
    end else begin
      f = lru_idx;
    end
    evict = !hit && !empty_found;
    faults_next = faults;
    if (!hit && (faults != '1)) begin
      faults_next = faults + FAULT_W'(1);
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (order[i] == f) pos = FIDX_W'(i);
    end
    for (int i = 0; i < FRAMES - 1; i++) begin
      if (FIDX_W'(i) < pos) begin
        order_next[i] = order[i];
      end else begin
        order_next[i] = order[i+1];
      end
    end
    order_next[FRAMES-1] = f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
      frame_valid   <= '0;
      faults        <= '0;
      for (int i = 0; i < FRAMES; i++) order[i] <= FIDX_W'(i);
    end else begin
      if (cfg_we) frames_in_use <= cfg_data;
      if (cmd.execute) begin
        if (last_q) begin
          frame_valid <= '0;
          faults      <= '0;
          for (int i = 0; i < FRAMES; i++) order[i] <= FIDX_W'(i);
        end else begin
          frame_valid[f] <= 1'b1;
          faults         <= faults_next;
          order          <= order_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_q <= page;
      last_q <= end_of_string;
    end
    if (cmd.execute) begin
      if (!hit) frame_page[f] <= page_q;
      res.hit           <= hit;
      res.frame         <= FRAME_W'(f);
      res.evicted_valid <= evict;
      res.evicted_page  <= evict ? EVPAGE_W'(frame_page[f]) : '0;
      res.fault_count   <= faults_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/lru_page_replacement_core.sv -----
// Top level of the LRU page replacement block.
//
// The block tracks up to eight page frames with least recently used
// replacement. Each request on req carries one page reference and an
// end-of-string flag; each produces exactly one result on res with hit,
// frame index, evicted page and the running fault count.
// A request is taken in the idle state, looked up and applied in the
// execute state, and its result is presented in the hold state until res.ready.
// One request is in flight at a time: no new reference is taken until
// the last has passed the capture, lookup and hold steps. If the receiver
// stalls, req.ready stays low until the result is taken. After a request
// with the end-of-string flag, all frames empty, the recency order returns
// to ascending frame order and the count clears. Reset does the same and
// sets frames_in_use to eight. The user must write the register through
// cfg_we and cfg_data while the block is idle; this is not enforced.
`timescale 1ns / 1ps
`default_nettype none
module lru_page_replacement_core import lpr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  lpr_in_if.sink                req,
  lpr_out_if.source             res,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data
);

  cmd_t cmd;
  res_t result;

  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .cmd       (cmd)
  );

  lpr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .page          (req.page),
    .end_of_string (req.end_of_string),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .res           (result)
  );

  assign res.hit           = result.hit;
  assign res.frame         = result.frame;
  assign res.evicted_valid = result.evicted_valid;
  assign res.evicted_page  = result.evicted_page;
  assign res.fault_count   = result.fault_count;

endmodule
`default_nettype wire

// ----- src/lpr_checker.sv -----
// Port-level checker of the LRU page replacement block and its bind.
`timescale 1ns / 1ps
`default_nettype none
module lpr_checker import lpr_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire logic                res_valid,
  input wire logic                res_ready,
  input wire logic                res_hit,
  input wire logic                res_evicted_valid,
  input wire logic [EVPAGE_W-1:0] res_evicted_page
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("Result dropped before it was taken.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && res_valid))
    else $error("New request accepted while a result is pending.");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready ##1 res_valid)
    else $error("Request was not followed by its result.");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_evicted_valid |-> !res_hit)
    else $error("Eviction reported on a hit.");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_evicted_valid |-> res_evicted_page == '0)
    else $error("Evicted page is nonzero without an eviction.");

endmodule

bind lru_page_replacement_core lpr_checker u_lpr_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_hit           (res.hit),
  .res_evicted_valid (res.evicted_valid),
  .res_evicted_page  (res.evicted_page)
);
`default_nettype wire
